>>> sv/ecsm_pkg.sv
`timescale 1ns / 1ps

package ecsm_pkg;

  // field width used for all coordinate arithmetic
  localparam int FB = 64;
  // width of the register and coordinate ports
  localparam int DW = 64;
  // bit counter width inside the arithmetic unit
  localparam int CW = $clog2(FB);

  localparam logic [DW-1:0] PRIME_RESET = 64'd2305843009213693951;
  localparam logic [DW-1:0] CURVE_A_RESET = 64'd0;

  // configuration register indexes
  localparam logic CFG_PRIME = 1'b0;
  localparam logic CFG_CURVE_A = 1'b1;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT_A,
    S_INIT_X,
    S_INIT_Y,
    S_BIT,
    S_DBL_CHK,
    S_NEXT,
    S_PO_D1,
    S_PO_D2,
    S_PO_D3,
    S_PO_D4,
    S_PO_D5,
    S_PO_A1,
    S_PO_A2,
    S_INV_INIT,
    S_INV_TEST,
    S_INV_DIV,
    S_INV_QM,
    S_INV_MUL,
    S_INV_SUB,
    S_INV_END,
    S_INV_M,
    S_T1,
    S_T2,
    S_T3,
    S_T4,
    S_T5,
    S_T6,
    S_WB,
    S_FIN
  } state_t;

  // modular add of two reduced values
  function automatic logic [FB-1:0] madd(input logic [FB-1:0] a, input logic [FB-1:0] b,
                                         input logic [FB-1:0] p);
    logic [FB:0] s;
    logic [FB:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = s - {1'b0, p};
    madd = (s >= {1'b0, p}) ? d[FB-1:0] : s[FB-1:0];
  endfunction

  // modular subtract of two reduced values
  function automatic logic [FB-1:0] msub(input logic [FB-1:0] a, input logic [FB-1:0] b,
                                         input logic [FB-1:0] p);
    msub = (a >= b) ? (a - b) : (a + (p - b));
  endfunction

endpackage

>>> sv/ec_point_scalar_multiply.sv
`timescale 1ns / 1ps
// flow: infinite input, zero scalar or modulus below two: straight to the finish state,
//   then the result register; otherwise a, x and y are reduced mod p, then per scalar bit
//   a doubling and, for a set bit, an addition, each with a euclid inverse of R rounds (up to
//   about 92 for a 64-bit p)
// requests: one at a time, in_ready only while idle, the result register lets in
//   the next request; reset: synchronous active high, to idle, config p = 2^61-1, a = 0

module ec_point_scalar_multiply (
  input  logic                    clk,
  input  logic                    rst,
  // configuration write port
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [ecsm_pkg::DW-1:0] cfg_data,
  // input request channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [ecsm_pkg::DW-1:0] point_x,
  input  logic [ecsm_pkg::DW-1:0] point_y,
  input  logic                    point_at_infinity,
  input  logic [ecsm_pkg::DW-1:0] scalar,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ecsm_pkg::DW-1:0] result_x,
  output logic [ecsm_pkg::DW-1:0] result_y,
  output logic                    result_at_infinity,
  output logic                    division_error
);

  ecsm_pkg::state_t state;
  ecsm_pkg::state_t state_next;

  // configuration
  logic [ecsm_pkg::DW-1:0] prime_modulus;
  logic [ecsm_pkg::DW-1:0] curve_a;
  logic [ecsm_pkg::FB-1:0] pmod;

  // shared arithmetic unit
  ecsm_pkg::alu_ctl_t      alu_ctl;
  logic [ecsm_pkg::FB-1:0] alu_a;
  logic [ecsm_pkg::FB-1:0] alu_b;
  logic                    alu_done;
  logic [ecsm_pkg::FB-1:0] alu_res;
  logic [ecsm_pkg::FB-1:0] alu_quo;
  logic                    use_alu;
  logic                    pend;

  // accumulator and running point
  logic                    acc_inf;
  logic [ecsm_pkg::FB-1:0] ax;
  logic [ecsm_pkg::FB-1:0] ay;
  logic                    pp_inf;
  logic [ecsm_pkg::FB-1:0] px;
  logic [ecsm_pkg::FB-1:0] py;
  logic [ecsm_pkg::DW-1:0] n;
  logic [ecsm_pkg::FB-1:0] fa;
  logic                    derr;

  // point operation operands and temporaries
  logic [ecsm_pkg::FB-1:0] ux;
  logic [ecsm_pkg::FB-1:0] uy;
  logic [ecsm_pkg::FB-1:0] vx;
  logic [ecsm_pkg::FB-1:0] vy;
  logic                    to_acc;
  logic [ecsm_pkg::FB-1:0] t0;
  logic [ecsm_pkg::FB-1:0] t1;
  logic [ecsm_pkg::FB-1:0] t2;
  logic [ecsm_pkg::FB-1:0] t3;
  logic [ecsm_pkg::FB-1:0] m;

  // euclid state: remainders r0/r1, cofactors e0/e1, quotient q
  logic [ecsm_pkg::FB-1:0] r0;
  logic [ecsm_pkg::FB-1:0] r1;
  logic [ecsm_pkg::FB-1:0] e0;
  logic [ecsm_pkg::FB-1:0] e1;
  logic [ecsm_pkg::FB-1:0] q;

  logic                    in_acc;
  logic                    skip;
  logic                    out_load;
  logic [ecsm_pkg::FB-1:0] neg_ay;
  logic [ecsm_pkg::FB-1:0] neg_py;
  logic                    add_neg;
  logic                    add_eq;
  logic                    dbl_inf;

  assign pmod = prime_modulus[ecsm_pkg::FB-1:0];
  assign in_ready = (state == ecsm_pkg::S_IDLE);
  assign in_acc = in_valid && in_ready;
  // infinite input or zero scalar: straight to infinity; tiny modulus: infinity with error
  assign skip = point_at_infinity || (scalar == '0) || (pmod < ecsm_pkg::FB'(2));
  assign out_load = !out_valid || out_ready;

  // field negation of reduced values
  assign neg_ay = (ay == '0) ? '0 : (pmod - ay);
  assign neg_py = (py == '0) ? '0 : (pmod - py);
  // acc + pp with pp the negation of acc gives infinity
  assign add_neg = !acc_inf && !pp_inf && (ax == px) && (py == neg_ay);
  assign add_eq = (ax == px) && (ay == py);
  // doubling infinity or a point equal to its own negation gives infinity
  assign dbl_inf = pp_inf || (py == neg_py);

  ecsm_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .ctl  (alu_ctl),
    .a    (alu_a),
    .b    (alu_b),
    .p    (pmod),
    .done (alu_done),
    .res  (alu_res),
    .quo  (alu_quo)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ecsm_pkg::S_IDLE: begin
        if (in_acc) state_next = skip ? ecsm_pkg::S_FIN : ecsm_pkg::S_INIT_A;
      end
      ecsm_pkg::S_INIT_A: if (alu_done) state_next = ecsm_pkg::S_INIT_X;
      ecsm_pkg::S_INIT_X: if (alu_done) state_next = ecsm_pkg::S_INIT_Y;
      ecsm_pkg::S_INIT_Y: if (alu_done) state_next = ecsm_pkg::S_BIT;
      ecsm_pkg::S_BIT: begin
        if (n[0] && !acc_inf && !pp_inf && !add_neg)
          state_next = add_eq ? ecsm_pkg::S_PO_D1 : ecsm_pkg::S_PO_A1;
        else
          state_next = ecsm_pkg::S_DBL_CHK;
      end
      ecsm_pkg::S_DBL_CHK: state_next = dbl_inf ? ecsm_pkg::S_NEXT : ecsm_pkg::S_PO_D1;
      ecsm_pkg::S_NEXT: begin
        state_next = (n[ecsm_pkg::DW-1:1] == '0) ? ecsm_pkg::S_FIN : ecsm_pkg::S_BIT;
      end
      ecsm_pkg::S_PO_D1: if (alu_done) state_next = ecsm_pkg::S_PO_D2;
      ecsm_pkg::S_PO_D2: if (alu_done) state_next = ecsm_pkg::S_PO_D3;
      ecsm_pkg::S_PO_D3: if (alu_done) state_next = ecsm_pkg::S_PO_D4;
      ecsm_pkg::S_PO_D4: if (alu_done) state_next = ecsm_pkg::S_PO_D5;
      ecsm_pkg::S_PO_D5: if (alu_done) state_next = ecsm_pkg::S_INV_INIT;
      ecsm_pkg::S_PO_A1: if (alu_done) state_next = ecsm_pkg::S_PO_A2;
      ecsm_pkg::S_PO_A2: if (alu_done) state_next = ecsm_pkg::S_INV_INIT;
      ecsm_pkg::S_INV_INIT: state_next = ecsm_pkg::S_INV_TEST;
      ecsm_pkg::S_INV_TEST: begin
        state_next = (r1 == '0) ? ecsm_pkg::S_INV_END : ecsm_pkg::S_INV_DIV;
      end
      ecsm_pkg::S_INV_DIV: if (alu_done) state_next = ecsm_pkg::S_INV_QM;
      ecsm_pkg::S_INV_QM:  if (alu_done) state_next = ecsm_pkg::S_INV_MUL;
      ecsm_pkg::S_INV_MUL: if (alu_done) state_next = ecsm_pkg::S_INV_SUB;
      ecsm_pkg::S_INV_SUB: if (alu_done) state_next = ecsm_pkg::S_INV_TEST;
      ecsm_pkg::S_INV_END: begin
        state_next = (r0 != ecsm_pkg::FB'(1)) ? ecsm_pkg::S_T1 : ecsm_pkg::S_INV_M;
      end
      ecsm_pkg::S_INV_M: if (alu_done) state_next = ecsm_pkg::S_T1;
      ecsm_pkg::S_T1: if (alu_done) state_next = ecsm_pkg::S_T2;
      ecsm_pkg::S_T2: if (alu_done) state_next = ecsm_pkg::S_T3;
      ecsm_pkg::S_T3: if (alu_done) state_next = ecsm_pkg::S_T4;
      ecsm_pkg::S_T4: if (alu_done) state_next = ecsm_pkg::S_T5;
      ecsm_pkg::S_T5: if (alu_done) state_next = ecsm_pkg::S_T6;
      ecsm_pkg::S_T6: if (alu_done) state_next = ecsm_pkg::S_WB;
      ecsm_pkg::S_WB: state_next = to_acc ? ecsm_pkg::S_DBL_CHK : ecsm_pkg::S_NEXT;
      ecsm_pkg::S_FIN: if (out_load) state_next = ecsm_pkg::S_IDLE;
      default: state_next = ecsm_pkg::S_IDLE;
    endcase
  end

  // arithmetic unit requests per state
  always_comb begin
    use_alu = 1'b1;
    alu_ctl.op = ecsm_pkg::ALU_ADD;
    alu_a = '0;
    alu_b = '0;
    case (state)
      ecsm_pkg::S_INIT_A: begin
        alu_ctl.op = ecsm_pkg::ALU_DIV;
        alu_a = curve_a[ecsm_pkg::FB-1:0];
        alu_b = pmod;
      end
      ecsm_pkg::S_INIT_X: begin
        alu_ctl.op = ecsm_pkg::ALU_DIV;
        alu_a = px;
        alu_b = pmod;
      end
      ecsm_pkg::S_INIT_Y: begin
        alu_ctl.op = ecsm_pkg::ALU_DIV;
        alu_a = py;
        alu_b = pmod;
      end
      // doubling: num = 3x^2 + a, den = 2y
      ecsm_pkg::S_PO_D1: begin
        alu_ctl.op = ecsm_pkg::ALU_MUL;
        alu_a = ux;
        alu_b = ux;
      end
      ecsm_pkg::S_PO_D2: begin
        alu_a = t0;
        alu_b = t0;
      end
      ecsm_pkg::S_PO_D3: begin
        alu_a = t1;
        alu_b = t0;
      end
      ecsm_pkg::S_PO_D4: begin
        alu_a = t1;
        alu_b = fa;
      end
      ecsm_pkg::S_PO_D5: begin
        alu_a = uy;
        alu_b = uy;
      end
      // addition: num = y2 - y1, den = x2 - x1
      ecsm_pkg::S_PO_A1: begin
        alu_ctl.op = ecsm_pkg::ALU_SUB;
        alu_a = vy;
        alu_b = uy;
      end
      ecsm_pkg::S_PO_A2: begin
        alu_ctl.op = ecsm_pkg::ALU_SUB;
        alu_a = vx;
        alu_b = ux;
      end
      ecsm_pkg::S_INV_DIV: begin
        alu_ctl.op = ecsm_pkg::ALU_DIV;
        alu_a = r0;
        alu_b = r1;
      end
      ecsm_pkg::S_INV_QM: begin
        alu_a = q;
      end
      ecsm_pkg::S_INV_MUL: begin
        alu_ctl.op = ecsm_pkg::ALU_MUL;
        alu_a = q;
        alu_b = e1;
      end
      ecsm_pkg::S_INV_SUB: begin
        alu_ctl.op = ecsm_pkg::ALU_SUB;
        alu_a = e0;
        alu_b = q;
      end
      ecsm_pkg::S_INV_M: begin
        alu_ctl.op = ecsm_pkg::ALU_MUL;
        alu_a = t1;
        alu_b = e0;
      end
      // common tail: x3 = m^2 - x1 - x2, y3 = m (x1 - x3) - y1
      ecsm_pkg::S_T1: begin
        alu_ctl.op = ecsm_pkg::ALU_MUL;
        alu_a = m;
        alu_b = m;
      end
      ecsm_pkg::S_T2: begin
        alu_a = ux;
        alu_b = vx;
      end
      ecsm_pkg::S_T3: begin
        alu_ctl.op = ecsm_pkg::ALU_SUB;
        alu_a = t0;
        alu_b = t3;
      end
      ecsm_pkg::S_T4: begin
        alu_ctl.op = ecsm_pkg::ALU_SUB;
        alu_a = ux;
        alu_b = t3;
      end
      ecsm_pkg::S_T5: begin
        alu_ctl.op = ecsm_pkg::ALU_MUL;
        alu_a = m;
        alu_b = t0;
      end
      ecsm_pkg::S_T6: begin
        alu_ctl.op = ecsm_pkg::ALU_SUB;
        alu_a = t0;
        alu_b = uy;
      end
      default: use_alu = 1'b0;
    endcase
    alu_ctl.start = use_alu && !pend;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ecsm_pkg::S_IDLE;
      pend <= 1'b0;
      out_valid <= 1'b0;
      prime_modulus <= ecsm_pkg::PRIME_RESET;
      curve_a <= ecsm_pkg::CURVE_A_RESET;
    end else begin
      state <= state_next;
      if (alu_ctl.start) pend <= 1'b1;
      else if (alu_done) pend <= 1'b0;
      if (state == ecsm_pkg::S_FIN && out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          ecsm_pkg::CFG_PRIME:   prime_modulus <= cfg_data;
          ecsm_pkg::CFG_CURVE_A: curve_a <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ecsm_pkg::S_IDLE: begin
        if (in_acc) begin
          px <= point_x[ecsm_pkg::FB-1:0];
          py <= point_y[ecsm_pkg::FB-1:0];
          n <= scalar;
          acc_inf <= 1'b1;
          pp_inf <= 1'b0;
          derr <= !point_at_infinity && (scalar != '0) && (pmod < ecsm_pkg::FB'(2));
        end
      end
      ecsm_pkg::S_INIT_A: if (alu_done) fa <= alu_res;
      ecsm_pkg::S_INIT_X: if (alu_done) px <= alu_res;
      ecsm_pkg::S_INIT_Y: if (alu_done) py <= alu_res;
      ecsm_pkg::S_BIT: begin
        if (n[0]) begin
          if (add_neg) begin
            acc_inf <= 1'b1;
          end else if (acc_inf && !pp_inf) begin
            acc_inf <= 1'b0;
            ax <= px;
            ay <= py;
          end else if (!acc_inf && !pp_inf) begin
            ux <= ax;
            uy <= ay;
            vx <= add_eq ? ax : px;
            vy <= py;
            to_acc <= 1'b1;
          end
        end
      end
      ecsm_pkg::S_DBL_CHK: begin
        if (dbl_inf) begin
          pp_inf <= 1'b1;
        end else begin
          ux <= px;
          uy <= py;
          vx <= px;
          to_acc <= 1'b0;
        end
      end
      ecsm_pkg::S_NEXT: n <= n >> 1;
      ecsm_pkg::S_PO_D1: if (alu_done) t0 <= alu_res;
      ecsm_pkg::S_PO_D2: if (alu_done) t1 <= alu_res;
      ecsm_pkg::S_PO_D3: if (alu_done) t1 <= alu_res;
      ecsm_pkg::S_PO_D4: if (alu_done) t1 <= alu_res;
      ecsm_pkg::S_PO_D5: if (alu_done) t2 <= alu_res;
      ecsm_pkg::S_PO_A1: if (alu_done) t1 <= alu_res;
      ecsm_pkg::S_PO_A2: if (alu_done) t2 <= alu_res;
      ecsm_pkg::S_INV_INIT: begin
        r0 <= pmod;
        r1 <= t2;
        e0 <= '0;
        e1 <= ecsm_pkg::FB'(1);
      end
      ecsm_pkg::S_INV_DIV: begin
        if (alu_done) begin
          q <= alu_quo;
          t3 <= alu_res;
        end
      end
      ecsm_pkg::S_INV_QM:  if (alu_done) q <= alu_res;
      ecsm_pkg::S_INV_MUL: if (alu_done) q <= alu_res;
      ecsm_pkg::S_INV_SUB: begin
        if (alu_done) begin
          e1 <= alu_res;
          e0 <= e1;
          r0 <= r1;
          r1 <= t3;
        end
      end
      ecsm_pkg::S_INV_END: begin
        // no inverse: quotient taken as zero, flag the error
        if (r0 != ecsm_pkg::FB'(1)) begin
          derr <= 1'b1;
          m <= '0;
        end
      end
      ecsm_pkg::S_INV_M: if (alu_done) m <= alu_res;
      ecsm_pkg::S_T1: if (alu_done) t0 <= alu_res;
      ecsm_pkg::S_T2: if (alu_done) t3 <= alu_res;
      ecsm_pkg::S_T3: if (alu_done) t3 <= alu_res;
      ecsm_pkg::S_T4: if (alu_done) t0 <= alu_res;
      ecsm_pkg::S_T5: if (alu_done) t0 <= alu_res;
      ecsm_pkg::S_T6: if (alu_done) t0 <= alu_res;
      ecsm_pkg::S_WB: begin
        if (to_acc) begin
          acc_inf <= 1'b0;
          ax <= t3;
          ay <= t0;
        end else begin
          pp_inf <= 1'b0;
          px <= t3;
          py <= t0;
        end
      end
      ecsm_pkg::S_FIN: begin
        if (out_load) begin
          result_x <= acc_inf ? '0 : ecsm_pkg::DW'(ax);
          result_y <= acc_inf ? '0 : ecsm_pkg::DW'(ay);
          result_at_infinity <= acc_inf;
          division_error <= derr;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> sv/ecsm_alu.sv
`timescale 1ns / 1ps

module ecsm_alu (
  input  logic                        clk,
  input  logic                        rst,
  input  ecsm_pkg::alu_ctl_t          ctl,
  input  logic [ecsm_pkg::FB-1:0]     a,
  input  logic [ecsm_pkg::FB-1:0]     b,
  input  logic [ecsm_pkg::FB-1:0]     p,
  output logic                        done,
  output logic [ecsm_pkg::FB-1:0]     res,
  output logic [ecsm_pkg::FB-1:0]     quo
);

  logic                    busy;
  ecsm_pkg::alu_op_t       op_r;
  logic                    phase;
  logic [ecsm_pkg::CW-1:0] cnt;
  logic [ecsm_pkg::FB-1:0] acc;
  logic [ecsm_pkg::FB-1:0] opa;
  logic [ecsm_pkg::FB-1:0] opb;
  logic [ecsm_pkg::FB-1:0] rem;

  logic [ecsm_pkg::FB-1:0] ma;
  logic [ecsm_pkg::FB-1:0] madd_out;
  logic [ecsm_pkg::FB:0]   remsh;
  logic [ecsm_pkg::FB:0]   diff;
  logic                    ge;
  logic [ecsm_pkg::FB-1:0] rem_next;
  logic [ecsm_pkg::FB-1:0] quo_next;

  // double phase adds acc to itself, add phase adds a when the multiplier bit is set
  assign ma = phase ? (opb[ecsm_pkg::FB-1] ? opa : '0) : acc;
  assign madd_out = ecsm_pkg::madd(acc, ma, p);

  // restoring division step
  assign remsh = {rem, quo[ecsm_pkg::FB-1]};
  assign diff = remsh - {1'b0, opb};
  assign ge = ~diff[ecsm_pkg::FB];
  assign rem_next = ge ? diff[ecsm_pkg::FB-1:0] : remsh[ecsm_pkg::FB-1:0];
  assign quo_next = {quo[ecsm_pkg::FB-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (ctl.start) begin
          op_r <= ctl.op;
          case (ctl.op)
            ecsm_pkg::ALU_ADD: begin
              res <= ecsm_pkg::madd(a, b, p);
              done <= 1'b1;
            end
            ecsm_pkg::ALU_SUB: begin
              res <= ecsm_pkg::msub(a, b, p);
              done <= 1'b1;
            end
            ecsm_pkg::ALU_MUL: begin
              busy <= 1'b1;
              acc <= '0;
              opa <= a;
              opb <= b;
              phase <= 1'b0;
              cnt <= ecsm_pkg::CW'(ecsm_pkg::FB - 1);
            end
            default: begin
              busy <= 1'b1;
              rem <= '0;
              quo <= a;
              opb <= b;
              cnt <= ecsm_pkg::CW'(ecsm_pkg::FB - 1);
            end
          endcase
        end
      end else begin
        case (op_r)
          ecsm_pkg::ALU_MUL: begin
            acc <= madd_out;
            phase <= ~phase;
            if (phase) begin
              opb <= opb << 1;
              if (cnt == '0) begin
                res <= madd_out;
                done <= 1'b1;
                busy <= 1'b0;
              end else begin
                cnt <= cnt - 1'b1;
              end
            end
          end
          default: begin
            rem <= rem_next;
            quo <= quo_next;
            if (cnt == '0) begin
              res <= rem_next;
              done <= 1'b1;
              busy <= 1'b0;
            end else begin
              cnt <= cnt - 1'b1;
            end
          end
        endcase
      end
    end
  end

endmodule

>>> sv/ecsm_checker.sv
`timescale 1ns / 1ps

module ecsm_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    cfg_we,
  input logic                    cfg_index,
  input logic [ecsm_pkg::DW-1:0] cfg_data,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [ecsm_pkg::DW-1:0] point_x,
  input logic [ecsm_pkg::DW-1:0] point_y,
  input logic                    point_at_infinity,
  input logic [ecsm_pkg::DW-1:0] scalar,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [ecsm_pkg::DW-1:0] result_x,
  input logic [ecsm_pkg::DW-1:0] result_y,
  input logic                    result_at_infinity,
  input logic                    division_error
);

  // one request at a time: accepting a request drops ready
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after a request was taken");

  // infinity is reported with zero coordinates
  a_inf_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_at_infinity |-> (result_x == '0) && (result_y == '0))
    else $error("infinite result with nonzero coordinates");

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_x) && $stable(result_y)
      && $stable(result_at_infinity) && $stable(division_error))
    else $error("result changed while stalled");

endmodule

bind ec_point_scalar_multiply ecsm_checker u_ecsm_checker (.*);

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

  // affine point as carried by the predictor
  typedef struct packed {
    logic        inf;
    logic [63:0] x;
    logic [63:0] y;
  } ec_point_t;

  // one predicted result
  typedef struct packed {
    logic [63:0] x;
    logic [63:0] y;
    logic        inf;
    logic        err;
  } product_t;

  localparam int WATCHDOG_LIMIT = 4000000;
  localparam logic [63:0] MAX_PRIME_64 = 64'd18446744073709551557;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = ecsm_pkg::CFG_PRIME;
  logic [ecsm_pkg::DW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ecsm_pkg::DW-1:0] point_x = '0;
  logic [ecsm_pkg::DW-1:0] point_y = '0;
  logic point_at_infinity = 1'b0;
  logic [ecsm_pkg::DW-1:0] scalar = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ecsm_pkg::DW-1:0] result_x;
  logic [ecsm_pkg::DW-1:0] result_y;
  logic result_at_infinity;
  logic division_error;

  // shadow copy of the configuration registers
  logic [63:0] modulus_reg = ecsm_pkg::PRIME_RESET;
  logic [63:0] coeff_a_reg = ecsm_pkg::CURVE_A_RESET;

  product_t pending_products[$];
  int mismatches = 0;
  bit idle_enable = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;

  always #6 clk = ~clk;

  ec_point_scalar_multiply u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .point_x(point_x), .point_y(point_y),
    .point_at_infinity(point_at_infinity), .scalar(scalar),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_x(result_x), .result_y(result_y),
    .result_at_infinity(result_at_infinity), .division_error(division_error)
  );

  // ---------------------------------------------------------------------------
  // field and point arithmetic of the predictor, all operands already reduced
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] fadd(input logic [63:0] a, b, p);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, p}) s = s - {1'b0, p};
    return s[63:0];
  endfunction

  function automatic logic [63:0] fsub(input logic [63:0] a, b, p);
    return (a >= b) ? (a - b) : (a + (p - b));
  endfunction

  function automatic logic [63:0] fmul(input logic [63:0] a, b, p);
    logic [127:0] t;
    t = {64'd0, a} * {64'd0, b};
    t = t % {64'd0, p};
    return t[63:0];
  endfunction

  // division through an extended euclid inverse, zero quotient on no inverse
  function automatic logic [63:0] fdiv(input logic [63:0] num, den, p, inout bit err);
    logic [63:0] r0, r1, t0, t1, q, nr, nt;
    r0 = p;
    r1 = den;
    t0 = '0;
    t1 = 64'd1 % p;
    while (r1 != 0) begin
      q = r0 / r1;
      nr = r0 - q * r1;
      nt = fsub(t0, fmul(q % p, t1, p), p);
      r0 = r1;
      r1 = nr;
      t0 = t1;
      t1 = nt;
    end
    if (r0 != 1) begin
      err = 1'b1;
      return '0;
    end
    return fmul(num, t0, p);
  endfunction

  function automatic ec_point_t pt_neg(input ec_point_t a, input logic [63:0] p);
    ec_point_t r;
    r = a;
    if (!a.inf) r.y = fsub(64'd0, a.y, p);
    return r;
  endfunction

  function automatic bit pt_same(input ec_point_t a, b);
    return (a.inf && b.inf) || (!a.inf && !b.inf && a.x == b.x && a.y == b.y);
  endfunction

  function automatic ec_point_t pt_double(input ec_point_t a, input logic [63:0] p, ca,
                                          inout bit err);
    ec_point_t r;
    logic [63:0] num, den, m;
    r = '{inf: 1'b1, x: 64'd0, y: 64'd0};
    // tangent is vertical when the point is its own negation
    if (a.inf || pt_same(pt_neg(a, p), a)) return r;
    num = fadd(fmul(fmul(a.x, a.x, p), 64'd3 % p, p), ca, p);
    den = fmul(a.y, 64'd2 % p, p);
    m = fdiv(num, den, p, err);
    r.inf = 1'b0;
    r.x = fsub(fmul(m, m, p), fadd(a.x, a.x, p), p);
    r.y = fsub(fmul(m, fsub(a.x, r.x, p), p), a.y, p);
    return r;
  endfunction

  function automatic ec_point_t pt_add(input ec_point_t a, b, input logic [63:0] p, ca,
                                       inout bit err);
    ec_point_t r;
    logic [63:0] m;
    r = '{inf: 1'b1, x: 64'd0, y: 64'd0};
    if ((a.inf && b.inf) || pt_same(b, pt_neg(a, p)) || pt_same(a, pt_neg(b, p))) return r;
    if (a.inf) return b;
    if (b.inf) return a;
    if (pt_same(a, b)) return pt_double(a, p, ca, err);
    m = fdiv(fsub(b.y, a.y, p), fsub(b.x, a.x, p), p, err);
    r.inf = 1'b0;
    r.x = fsub(fmul(m, m, p), fadd(b.x, a.x, p), p);
    r.y = fsub(fmul(m, fsub(a.x, r.x, p), p), a.y, p);
    return r;
  endfunction

  // right-to-left double-and-add on the current register settings
  function automatic product_t scalar_multiply_point(input logic [63:0] px, py,
                                                     input logic pinf,
                                                     input logic [63:0] k);
    ec_point_t acc, base;
    product_t res;
    bit err;
    logic [63:0] p, ca, n;
    err = 1'b0;
    acc = '{inf: 1'b1, x: 64'd0, y: 64'd0};
    p = modulus_reg;
    n = k;
    if (!pinf && n != 0) begin
      if (p < 2) begin
        err = 1'b1;
      end else begin
        ca = coeff_a_reg % p;
        base = '{inf: 1'b0, x: px % p, y: py % p};
        while (n != 0) begin
          if (n[0]) acc = pt_add(acc, base, p, ca, err);
          base = pt_double(base, p, ca, err);
          n = n >> 1;
        end
      end
    end
    res.x = acc.inf ? 64'd0 : acc.x;
    res.y = acc.inf ? 64'd0 : acc.y;
    res.inf = acc.inf;
    res.err = err;
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic [63:0] px, py, input logic pinf,
                              input logic [63:0] k);
    product_t prod;
    // random gap ahead of the request
    if (idle_enable && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 14)) @(posedge clk);
    prod = scalar_multiply_point(px, py, pinf, k);
    @(posedge clk);
    in_valid <= 1'b1;
    point_x <= px;
    point_y <= py;
    point_at_infinity <= pinf;
    scalar <= k;
    do @(posedge clk); while (!in_ready);
    pending_products.insert(pending_products.size(), prod);
    in_valid <= 1'b0;
  endtask

  // wait until every predicted result has been consumed
  task automatic drain();
    while (pending_products.size() != 0) @(posedge clk);
  endtask

  // register writes happen only with the block idle
  task automatic write_reg(input logic idx, input logic [63:0] val);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ecsm_pkg::CFG_PRIME) modulus_reg = val;
    else coeff_a_reg = val;
  endtask

  task automatic set_curve(input logic [63:0] p, ca);
    write_reg(ecsm_pkg::CFG_PRIME, p);
    write_reg(ecsm_pkg::CFG_CURVE_A, ca);
  endtask

  // ---------------------------------------------------------------------------
  // result checking, receiver stalls and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    product_t want;
    if (out_valid && out_ready) begin
      if (pending_products.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%h y=%h inf=%b err=%b",
                                       result_x, result_y, result_at_infinity, division_error);
      end else begin
        want = pending_products.pop_front();
        if (result_x !== want.x || result_y !== want.y ||
            result_at_infinity !== want.inf || division_error !== want.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp x=%h y=%h inf=%b err=%b got x=%h y=%h inf=%b err=%b",
                     want.x, want.y, want.inf, want.err,
                     result_x, result_y, result_at_infinity, division_error);
        end
      end
    end
    // receiver stall bursts
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
    // watchdog on cycles without any accepted request or result
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values of the registers, simple multiples and the trivial cases
  task automatic test_reset_defaults();
    logic [63:0] gx, gy;
    gx = rand64();
    gy = rand64();
    send_request(gx, gy, 1'b0, 64'd1);
    send_request(gx, gy, 1'b0, 64'd2);
    send_request(gx, gy, 1'b0, 64'd5);
    send_request(gx, gy, 1'b0, 64'd0);
    send_request(gx, gy, 1'b1, 64'd3);
  endtask

  // infinite input with every scalar bit set, doubling through y = 0,
  // coordinates at and beyond the modulus, high scalar bits on a tiny field
  task automatic test_special_cases();
    set_curve(64'd13, 64'd7);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
                 64'hFFFF_FFFF_FFFF_FFFF);
    // y equal to p reduces to zero, so doubling lands on infinity
    send_request(64'd4, 64'd13, 1'b0, 64'd2);
    send_request(64'd4, 64'd13, 1'b0, 64'd3);
    send_request(64'd30, 64'd27, 1'b0, 64'd1);
    send_request(64'd5, 64'd6, 1'b0, 64'h8000_0000_0000_0000);
    send_request(64'd9, 64'd2, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  // widest prime and widest coefficient with all-ones coordinates, then a field of three
  task automatic test_field_extremes();
    set_curve(MAX_PRIME_64, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'd3);
    send_request(64'd0, 64'd1, 1'b0, 64'd2);
    set_curve(64'd3, 64'd0);
    send_request(64'd1, 64'd1, 1'b0, 64'd6);
  endtask

  // moduli below two and composite moduli, where division can fail
  task automatic test_degenerate_modulus();
    set_curve(64'd0, 64'd5);
    send_request(64'd3, 64'd4, 1'b0, 64'd1);
    send_request(64'd3, 64'd4, 1'b1, 64'd1);
    write_reg(ecsm_pkg::CFG_PRIME, 64'd1);
    send_request(64'd3, 64'd4, 1'b0, 64'd7);
    send_request(64'd3, 64'd4, 1'b0, 64'd0);
    write_reg(ecsm_pkg::CFG_PRIME, 64'd2);
    send_request(64'd1, 64'd1, 1'b0, 64'd3);
    write_reg(ecsm_pkg::CFG_PRIME, 64'd4);
    send_request(64'd1, 64'd1, 1'b0, 64'd5);
    write_reg(ecsm_pkg::CFG_PRIME, 64'd15);
    send_request(64'd2, 64'd3, 1'b0, 64'd11);
    write_reg(ecsm_pkg::CFG_PRIME, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(rand64(), rand64(), 1'b0, 64'd3);
  endtask

  // random curves and points, mostly small fields so the run stays short
  task automatic test_random_multiples(input int n_items);
    logic [63:0] moduli[12];
    logic [63:0] k, ca;
    int phase_len;
    moduli = '{64'd5, 64'd7, 64'd13, 64'd251, 64'd65521, 64'd1000003, 64'd2147483647,
               ecsm_pkg::PRIME_RESET, MAX_PRIME_64, 64'd91, 64'd65535, 64'd17};
    phase_len = n_items / 5;
    for (int i = 0; i < n_items; i++) begin
      if (i % phase_len == 0) begin
        // last phase runs with no idling on either side
        if (i >= 4 * phase_len) idle_enable = 1'b0;
        case ($urandom_range(0, 3))
          0: ca = 64'd0;
          1: ca = 64'hFFFF_FFFF_FFFF_FFFF;
          default: ca = rand64();
        endcase
        if ($urandom_range(0, 4) == 0) set_curve(moduli[$urandom_range(0, 11)], ca);
        else set_curve(moduli[$urandom_range(0, 5)], ca);
      end
      case ($urandom_range(0, 11))
        0: k = 64'd0;
        1: k = (modulus_reg <= 251) ? rand64() : 64'($urandom_range(1, 15));
        default: k = 64'($urandom_range(1, (1 << $urandom_range(1, 6)) - 1));
      endcase
      // the widest fields only take very short scalars
      if (modulus_reg > 64'd2147483647 && k > 7) k = k & 64'd7;
      send_request(rand64(), rand64(), $urandom_range(0, 9) == 0, k);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_special_cases();
    test_field_extremes();
    test_degenerate_modulus();
    test_random_multiples(100);
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_products.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
